// File: sv/assert_macros.svh
// Assertion macros shared by the run-length encoder RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge, skipped while reset is applied.
`define SCRL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check a property on every clock edge, reset included.
`define SCRL_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// File: sv/scrl_pkg.sv
// Shared widths, limits and plan type for the sparse column run-length encoder.
`default_nettype none

package scrl_pkg;

  localparam int unsigned RowW = 20;
  localparam int unsigned LenW = 21;
  localparam int unsigned ValW = 64;
  localparam int unsigned PosW = 32;

  // Largest legal row count per column
  localparam logic [LenW-1:0] MaxRows = LenW'(1048576);

  // Input item kinds
  localparam logic KindEntry  = 1'b0;
  localparam logic KindColEnd = 1'b1;

  // Triples one item produces: optional zero run, optional value run
  typedef struct packed {
    logic            has_zero;
    logic [RowW-1:0] zero_start;
    logic [LenW-1:0] zero_len;
    logic            has_val;
  } plan_t;

endpackage

`default_nettype wire

// File: sv/scrl_plan.sv
// Works out the zero run and value run that one request produces.
`default_nettype none

module scrl_plan
  import scrl_pkg::*;
(
  input  logic            kind_i,
  input  logic [RowW-1:0] row_i,
  input  logic [RowW-1:0] prev_row_i,
  input  logic            entry_seen_i,
  input  logic [LenW-1:0] row_count_i,
  output plan_t           plan_o
);

  logic [LenW-1:0] row_ext;
  logic [LenW-1:0] next_row;

  assign row_ext  = LenW'(row_i);
  assign next_row = LenW'(prev_row_i) + LenW'(1);

  // Pick the run that fills the gap before the entry or after the column
  always_comb begin
    plan_o = '0;
    if (kind_i == KindEntry) begin
      plan_o.has_val = 1'b1;
      if (!entry_seen_i) begin
        plan_o.has_zero   = (row_i != '0);
        plan_o.zero_start = '0;
        plan_o.zero_len   = row_ext;
      end else begin
        plan_o.has_zero   = (row_ext > next_row);
        plan_o.zero_start = next_row[RowW-1:0];
        plan_o.zero_len   = row_ext - next_row;
      end
    end else begin
      if (!entry_seen_i) begin
        plan_o.has_zero   = 1'b1;
        plan_o.zero_start = '0;
        plan_o.zero_len   = row_count_i;
      end else begin
        plan_o.has_zero   = (next_row < row_count_i);
        plan_o.zero_start = next_row[RowW-1:0];
        plan_o.zero_len   = row_count_i - next_row;
      end
    end
  end

endmodule

`default_nettype wire

// File: sv/sparse_column_to_run_length_top.sv
// Top level of the sparse column run-length encoder.
//
//   port group    dir   handshake                payload
//   in_*          in    in_valid_i / in_stall_o  kind_i, row_i, value_i
//   out_*         out   out_valid_o / out_stall_i run_value_o, run_start_o,
//                                                run_length_o, position_o,
//                                                first_of_column_o, last_o
//   cfg_*         in    cfg_we_i                 cfg_wdata_i (row count)
//
// A request stays in the input register until every triple it yields is sent:
// an entry after a gap yields a zero run and then its value run, any other entry
// only its value run; a column end yields at most a zero run, or nothing.
// The single output register gives at most one triple per cycle, which sets the rate.
// Reset clears the column state, the position count and sets the row count to one.
// A stalled output holds the triple and backs up into the input register.
`default_nettype none
`include "assert_macros.svh"

module sparse_column_to_run_length_top
  import scrl_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [LenW-1:0] cfg_wdata_i,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  logic            kind_i,
  input  logic [RowW-1:0] row_i,
  input  logic [ValW-1:0] value_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output logic [ValW-1:0] run_value_o,
  output logic [RowW-1:0] run_start_o,
  output logic [LenW-1:0] run_length_o,
  output logic [PosW-1:0] position_o,
  output logic            first_of_column_o,
  output logic            last_o
);

  logic [LenW-1:0] row_count_q;
  logic            in_valid_q;
  logic            kind_q;
  logic [RowW-1:0] row_q;
  logic [ValW-1:0] value_q;
  logic            phase_q, phase_d;
  logic [RowW-1:0] prev_row_q;
  logic            entry_seen_q;
  logic [PosW-1:0] count_q;
  logic            col_pending_q;
  logic            out_valid_q;
  logic [ValW-1:0] run_value_q;
  logic [RowW-1:0] run_start_q;
  logic [LenW-1:0] run_length_q;
  logic [PosW-1:0] position_q;
  logic            first_q;
  logic            last_q;

  plan_t           plan;
  logic            emit_zero;
  logic            has_triple;
  logic            cur_last;
  logic            out_ready;
  logic            emit_fire;
  logic            done;
  logic            in_accept;

  scrl_plan u_plan (
    .kind_i       (kind_q),
    .row_i        (row_q),
    .prev_row_i   (prev_row_q),
    .entry_seen_i (entry_seen_q),
    .row_count_i  (row_count_q),
    .plan_o       (plan)
  );

  // Choose the triple to send this cycle
  assign emit_zero  = !phase_q && plan.has_zero;
  assign has_triple = emit_zero || plan.has_val;
  assign cur_last   = !(emit_zero && plan.has_val);
  assign out_ready  = !out_valid_q || !out_stall_i;
  assign emit_fire  = in_valid_q && has_triple && out_ready;
  assign done       = in_valid_q && (!has_triple || (out_ready && cur_last));
  assign in_stall_o = in_valid_q && !done;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_comb begin
    phase_d = phase_q;
    if (done) begin
      phase_d = 1'b0;
    end else if (emit_fire) begin
      phase_d = 1'b1;
    end
  end

  // Store the clamped row count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_count_q <= LenW'(1);
    end else if (cfg_we_i) begin
      if (cfg_wdata_i == '0) begin
        row_count_q <= LenW'(1);
      end else if (cfg_wdata_i > MaxRows) begin
        row_count_q <= MaxRows;
      end else begin
        row_count_q <= cfg_wdata_i;
      end
    end
  end

  // Hold the current request and its progress
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      phase_q    <= 1'b0;
    end else begin
      phase_q <= phase_d;
      if (in_accept) begin
        in_valid_q <= 1'b1;
      end else if (done) begin
        in_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      kind_q  <= kind_i;
      row_q   <= row_i;
      value_q <= value_i;
    end
  end

  // Advance the column state when a request completes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_row_q   <= '0;
      entry_seen_q <= 1'b0;
    end else if (done) begin
      if (kind_q == KindEntry) begin
        prev_row_q   <= row_q;
        entry_seen_q <= 1'b1;
      end else begin
        entry_seen_q <= 1'b0;
      end
    end
  end

  // Count triples, saturate, and track the column opening
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q       <= '0;
      col_pending_q <= 1'b1;
    end else begin
      if (emit_fire && (count_q != '1)) begin
        count_q <= count_q + PosW'(1);
      end
      if (done && (kind_q == KindColEnd)) begin
        col_pending_q <= 1'b1;
      end else if (emit_fire) begin
        col_pending_q <= 1'b0;
      end
    end
  end

  // Load the output register, drop it once taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit_fire) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_fire) begin
      if (emit_zero) begin
        run_value_q  <= '0;
        run_start_q  <= plan.zero_start;
        run_length_q <= plan.zero_len;
      end else begin
        run_value_q  <= value_q;
        run_start_q  <= row_q;
        run_length_q <= LenW'(1);
      end
      position_q <= count_q;
      first_q    <= col_pending_q;
      last_q     <= cur_last;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign run_value_o       = run_value_q;
  assign run_start_o       = run_start_q;
  assign run_length_o      = run_length_q;
  assign position_o        = position_q;
  assign first_of_column_o = first_q;
  assign last_o            = last_q;

  // Second phase only for an entry that still owes its value run
  `SCRL_ASSERT(a_phase_entry, phase_q |-> (in_valid_q && (kind_q == KindEntry)), "phase without entry")
  // Only a zero run can precede another triple of the same request
  `SCRL_ASSERT(a_mid_zero, (out_valid_q && !last_q) |-> (run_value_q == '0), "nonzero early triple")
  // No run is empty
  `SCRL_ASSERT(a_len_nz, out_valid_q |-> (run_length_q != '0), "empty run")
  // Row count stays in its legal range
  `SCRL_ASSERT(a_rc_range, (row_count_q != '0) && (row_count_q <= MaxRows), "row count out of range")

endmodule

`default_nettype wire
